### rtl/core/tzk_pkg.sv
// ----------------------------------------------------------------------------
// tzk_pkg
// Shared types and constants of the touch zone to key event block.
// ----------------------------------------------------------------------------
package tzk_pkg;

	localparam int unsigned NUM_ZONES  = 3;
	localparam int unsigned COORD_W    = 16;
	localparam int unsigned POS_W      = 12;
	localparam int unsigned TOL_W      = 10;
	localparam int unsigned KEY_W      = 10;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 12;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// event kinds carried on the input tuser
	typedef enum logic [1:0] {
		FUNC_TOUCH     = 2'd0,
		FUNC_POS_X     = 2'd1,
		FUNC_POS_Y     = 2'd2,
		FUNC_FRAME_END = 2'd3
	} func_t;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TARGET_ROW     = 3'd0,
		REG_ZONE_TOLERANCE = 3'd1,
		REG_ZONE0_CENTER   = 3'd2,
		REG_ZONE1_CENTER   = 3'd3,
		REG_ZONE2_CENTER   = 3'd4,
		REG_ZONE0_KEY      = 3'd5,
		REG_ZONE1_KEY      = 3'd6,
		REG_ZONE2_KEY      = 3'd7
	} cfg_reg_t;

	localparam logic [POS_W-1:0] RST_TARGET_ROW     = 12'd2040;
	localparam logic [TOL_W-1:0] RST_ZONE_TOLERANCE = 10'd50;
	localparam logic [POS_W-1:0] RST_ZONE0_CENTER   = 12'd200;
	localparam logic [POS_W-1:0] RST_ZONE1_CENTER   = 12'd500;
	localparam logic [POS_W-1:0] RST_ZONE2_CENTER   = 12'd800;
	localparam logic [KEY_W-1:0] RST_ZONE0_KEY      = 10'd580;
	localparam logic [KEY_W-1:0] RST_ZONE1_KEY      = 10'd125;
	localparam logic [KEY_W-1:0] RST_ZONE2_KEY      = 10'd158;

	typedef struct packed {
		logic [POS_W-1:0]                  target_row;
		logic [TOL_W-1:0]                  tolerance;
		logic [NUM_ZONES-1:0][POS_W-1:0]   center;
		logic [NUM_ZONES-1:0][KEY_W-1:0]   key;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_id;
		logic             pressed;
		logic             last;
	} result_t;

endpackage

### rtl/core/tzk_cfg_regs.sv
// ----------------------------------------------------------------------------
// tzk_cfg_regs
// Configuration register file with write channel.
// ----------------------------------------------------------------------------
module tzk_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tzk_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tzk_pkg::CFG_DATA_W-1:0] cfg_data,
	output tzk_pkg::cfg_t                  cfg
);
	import tzk_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_row <= RST_TARGET_ROW;
			cfg_q.tolerance  <= RST_ZONE_TOLERANCE;
			cfg_q.center[0]  <= RST_ZONE0_CENTER;
			cfg_q.center[1]  <= RST_ZONE1_CENTER;
			cfg_q.center[2]  <= RST_ZONE2_CENTER;
			cfg_q.key[0]     <= RST_ZONE0_KEY;
			cfg_q.key[1]     <= RST_ZONE1_KEY;
			cfg_q.key[2]     <= RST_ZONE2_KEY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_addr))
				REG_TARGET_ROW:     cfg_q.target_row <= cfg_data[POS_W-1:0];
				REG_ZONE_TOLERANCE: cfg_q.tolerance  <= cfg_data[TOL_W-1:0];
				REG_ZONE0_CENTER:   cfg_q.center[0]  <= cfg_data[POS_W-1:0];
				REG_ZONE1_CENTER:   cfg_q.center[1]  <= cfg_data[POS_W-1:0];
				REG_ZONE2_CENTER:   cfg_q.center[2]  <= cfg_data[POS_W-1:0];
				REG_ZONE0_KEY:      cfg_q.key[0]     <= cfg_data[KEY_W-1:0];
				REG_ZONE1_KEY:      cfg_q.key[1]     <= cfg_data[KEY_W-1:0];
				REG_ZONE2_KEY:      cfg_q.key[2]     <= cfg_data[KEY_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/tzk_zone_match.sv
// ----------------------------------------------------------------------------
// tzk_zone_match
// Window compare of X against all zones, lowest enabled hit wins.
// ----------------------------------------------------------------------------
module tzk_zone_match (
	input  tzk_pkg::cfg_t                    cfg,
	input  logic signed [tzk_pkg::COORD_W-1:0] pos_x,
	output logic [tzk_pkg::KEY_W-1:0]        key
);
	import tzk_pkg::*;

	localparam int unsigned CMP_W = COORD_W + 2;

	logic signed [CMP_W-1:0] x_w;
	logic [NUM_ZONES-1:0]    hit;

	assign x_w = CMP_W'(pos_x);

	for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
		logic signed [CMP_W-1:0] lo;
		logic signed [CMP_W-1:0] hi;
		assign lo     = $signed(CMP_W'(cfg.center[z])) - $signed(CMP_W'(cfg.tolerance));
		assign hi     = $signed(CMP_W'(cfg.center[z])) + $signed(CMP_W'(cfg.tolerance));
		assign hit[z] = (cfg.key[z] != '0) && (x_w >= lo) && (x_w <= hi);
	end

	// walk from the last zone down so that zone 0 has the final word
	always_comb begin
		key = '0;
		for (int i = NUM_ZONES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				key = cfg.key[i];
			end
		end
	end

endmodule

### rtl/core/tzk_out_fifo.sv
// ----------------------------------------------------------------------------
// tzk_out_fifo
// Small result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module tzk_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  tzk_pkg::result_t push_d0,
	input  tzk_pkg::result_t push_d1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output tzk_pkg::result_t out_data
);
	import tzk_pkg::*;

	result_t               mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	// room for a worst-case pair, ignoring a pop in the same cycle
	assign room      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			mem[wr_ptr_q + FIFO_PTR_W'(1)] <= push_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

### rtl/core/touch_zone_to_key_events.sv
// ----------------------------------------------------------------------------
// touch_zone_to_key_events
// Turns a decoded touch event stream into navigation key press and release beats.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser = func, tdata = event_value
//  m_*      | out       | tdata[9:0] = key_id, tuser = pressed, tlast = last
//  cfg_*    | in        | cfg_addr = register index, cfg_data = value
//
//  An input beat is registered, then handled by one pass of state update and
//  three-window compare once the output queue has room for a pair; one beat
//  per cycle is sustained while it keeps that room. A frame end that moves the
//  held key writes one or two results into a four-entry output queue; the
//  input stage waits while fewer than two entries are free.
//  Reset returns the registers to their defaults, clears touch and held key,
//  and sets both positions to all ones. A stalled m_tready backs up the queue
//  and then the input stage; nothing is dropped.
// ----------------------------------------------------------------------------
module touch_zone_to_key_events (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tzk_pkg::COORD_W-1:0]    s_tdata,   // [15:0] event_value
	input  logic [1:0]                     s_tuser,   // [1:0] func
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tzk_pkg::OUT_DATA_W-1:0] m_tdata,   // [9:0] key_id, [15:10] zero
	output logic                           m_tuser,   // [0] pressed
	output logic                           m_tlast,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tzk_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tzk_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tzk_pkg::*;

	cfg_t cfg;

	// input register
	logic                      valid_s1;
	func_t                     func_s1;
	logic signed [COORD_W-1:0] value_s1;

	// tracked touch state
	logic                      touch_q;
	logic signed [COORD_W-1:0] pos_x_q;
	logic signed [COORD_W-1:0] pos_y_q;
	logic [KEY_W-1:0]          held_q;

	logic             room;
	logic             advance;
	logic             frame_end;
	logic [KEY_W-1:0] zone_key;
	logic [KEY_W-1:0] target;
	logic             row_hit;
	logic             do_release;
	logic             do_press;
	logic [1:0]       push_n;
	result_t          push_d0;
	result_t          push_d1;
	result_t          out_data;

	tzk_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// advance the registered beat only when the queue can take a pair
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= func_t'(s_tuser);
			value_s1 <= s_tdata;
		end
	end

	tzk_zone_match u_match (
		.cfg   (cfg),
		.pos_x (pos_x_q),
		.key   (zone_key)
	);

	// a key row needs touch down and Y equal to the row register
	assign row_hit    = touch_q && (pos_y_q == $signed(COORD_W'(cfg.target_row)));
	assign target     = row_hit ? zone_key : '0;
	assign frame_end  = advance && (func_s1 == FUNC_FRAME_END);
	assign do_release = frame_end && (target != held_q) && (held_q != '0);
	assign do_press   = frame_end && (target != held_q) && (target != '0);
	assign push_n     = 2'(do_release) + 2'(do_press);

	// release goes first; it is last only when no press follows
	always_comb begin
		push_d1.key_id  = target;
		push_d1.pressed = 1'b1;
		push_d1.last    = 1'b1;
		if (do_release) begin
			push_d0.key_id  = held_q;
			push_d0.pressed = 1'b0;
			push_d0.last    = !do_press;
		end else begin
			push_d0 = push_d1;
		end
	end

	// update the tracked state as each beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_q <= 1'b0;
			pos_x_q <= '1;
			pos_y_q <= '1;
			held_q  <= '0;
		end else if (advance) begin
			case (func_s1)
				FUNC_TOUCH:     touch_q <= value_s1 != '0;
				FUNC_POS_X:     pos_x_q <= value_s1;
				FUNC_POS_Y:     pos_y_q <= value_s1;
				FUNC_FRAME_END: held_q  <= target;
				default: begin
				end
			endcase
		end
	end

	tzk_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_d0   (push_d0),
		.push_d1   (push_d1),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = OUT_DATA_W'(out_data.key_id);
	assign m_tuser = out_data.pressed;
	assign m_tlast = out_data.last;

	// a pair is always release then press, with last on the press only
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (!push_d0.pressed && !push_d0.last &&
			push_d1.pressed && push_d1.last))
		else $error("result pair out of order");

	// no result ever names key zero
	a_no_null_key: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (push_d0.key_id != '0))
		else $error("result with empty key");

	// the held key moves only on a frame end leaving the input register
	a_held_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_end |=> $stable(held_q))
		else $error("held key changed outside a frame end");

	// input stalls only behind a queue short of room for a pair, with a beat waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && !room && m_tvalid))
		else $error("input stalled without cause");

endmodule

### tb/tzk_key_event_checker.sv
// ----------------------------------------------------------------------------
// tzk_key_event_checker
// Predicts the key press and release beats of touch_zone_to_key_events from
// the observed input and configuration beats, and compares every result beat
// field by field with the oldest beat still due.
// ----------------------------------------------------------------------------
module tzk_key_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tzk_pkg::COORD_W-1:0]    s_tdata,    // [15:0] event_value
	input  logic [1:0]                     s_tuser,    // [1:0] func
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tzk_pkg::OUT_DATA_W-1:0] m_tdata,    // [9:0] key_id, [15:10] zero
	input  logic                           m_tuser,    // [0] pressed
	input  logic                           m_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tzk_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tzk_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);

	import tzk_pkg::*;

	// configuration copy
	logic [POS_W-1:0] row_sel;
	logic [TOL_W-1:0] half_width;
	logic [POS_W-1:0] zone_center [NUM_ZONES];
	logic [KEY_W-1:0] zone_key    [NUM_ZONES];

	// touch state copy
	logic                    finger_down;
	logic [COORD_W-1:0]      last_x;
	logic [COORD_W-1:0]      last_y;
	logic [KEY_W-1:0]        held;
	logic [KEY_W-1:0]        wanted;

	result_t key_events_due [$];
	result_t head;
	result_t seen;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// first enabled window that holds x wins; zone 0 is tried first
	function automatic logic [KEY_W-1:0] zone_key_at(input logic signed [COORD_W-1:0] x);
		int xi;
		int lo;
		int hi;
		xi = x;
		for (int z = 0; z < NUM_ZONES; z++) begin
			lo = int'(zone_center[z]) - int'(half_width);
			hi = int'(zone_center[z]) + int'(half_width);
			if (zone_key[z] != '0 && xi >= lo && xi <= hi)
				return zone_key[z];
		end
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sel        = RST_TARGET_ROW;
			half_width     = RST_ZONE_TOLERANCE;
			zone_center[0] = RST_ZONE0_CENTER;
			zone_center[1] = RST_ZONE1_CENTER;
			zone_center[2] = RST_ZONE2_CENTER;
			zone_key[0]    = RST_ZONE0_KEY;
			zone_key[1]    = RST_ZONE1_KEY;
			zone_key[2]    = RST_ZONE2_KEY;
			finger_down    = 1'b0;
			last_x         = '1;
			last_y         = '1;
			held           = '0;
			key_events_due.delete();
			outstanding    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.key_id  = m_tdata[KEY_W-1:0];
				seen.pressed = m_tuser;
				seen.last    = m_tlast;
				if (key_events_due.size() == 0) begin
					report_mismatch("result beat with none due, key_id", seen.key_id, 0);
				end else begin
					head = key_events_due.pop_front();
					if (seen.key_id != head.key_id)
						report_mismatch("key_id", seen.key_id, head.key_id);
					if (seen.pressed != head.pressed)
						report_mismatch("pressed", seen.pressed, head.pressed);
					if (seen.last != head.last)
						report_mismatch("last", seen.last, head.last);
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_addr))
					REG_TARGET_ROW:     row_sel        = cfg_data;
					REG_ZONE_TOLERANCE: half_width     = cfg_data[TOL_W-1:0];
					REG_ZONE0_CENTER:   zone_center[0] = cfg_data;
					REG_ZONE1_CENTER:   zone_center[1] = cfg_data;
					REG_ZONE2_CENTER:   zone_center[2] = cfg_data;
					REG_ZONE0_KEY:      zone_key[0]    = cfg_data[KEY_W-1:0];
					REG_ZONE1_KEY:      zone_key[1]    = cfg_data[KEY_W-1:0];
					REG_ZONE2_KEY:      zone_key[2]    = cfg_data[KEY_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				case (func_t'(s_tuser))
					FUNC_TOUCH:  finger_down = (s_tdata != '0);
					FUNC_POS_X:  last_x = s_tdata;
					FUNC_POS_Y:  last_y = s_tdata;
					default: begin
						wanted = '0;
						// Y must equal the row bit for bit; negative Y never does
						if (finger_down && last_y == {4'd0, row_sel})
							wanted = zone_key_at(last_x);
						if (wanted != held) begin
							if (held != '0) begin
								head.key_id  = held;
								head.pressed = 1'b0;
								head.last    = (wanted == '0);
								key_events_due.push_back(head);
							end
							if (wanted != '0) begin
								head.key_id  = wanted;
								head.pressed = 1'b1;
								head.last    = 1'b1;
								key_events_due.push_back(head);
							end
							held = wanted;
						end
					end
				endcase
			end

			outstanding = key_events_due.size();
		end
	end

endmodule

### tb/tb_touch_zone_to_key_events.sv
// ----------------------------------------------------------------------------
// tb_touch_zone_to_key_events
// Drives touch event beats and register writes into touch_zone_to_key_events.
// A directed opening walks the zones, window edges and coordinate extremes;
// then phases of well-formed touch frames with random content and some noise
// run under several register settings, with random gaps and output stalls.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_touch_zone_to_key_events;

	import tzk_pkg::*;

	typedef enum int {
		SET_DEFAULT,
		SET_HIGH,
		SET_LOW,
		SET_RANDOM
	} setting_kind_t;

	localparam int BEATS_PER_PHASE = 200;
	localparam int NUM_PHASES      = 8;
	localparam int SETTLE_CYCLES   = 8;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [COORD_W-1:0]      s_tdata   = '0;
	logic [1:0]              s_tuser   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tuser;
	logic                    m_tlast;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;

	int mismatches;
	int outstanding;

	// random gaps and stalls are only allowed while this is set
	bit idle_on = 1'b0;
	int stall_left = 0;
	int beats_sent = 0;

	// values last written, used to aim the random frames at the windows
	logic [11:0] sh_row;
	logic [11:0] sh_tol;
	logic [11:0] sh_center [NUM_ZONES];
	logic [11:0] sh_key    [NUM_ZONES];

	setting_kind_t phase_plan [NUM_PHASES] = '{SET_DEFAULT, SET_HIGH, SET_RANDOM, SET_LOW,
		SET_RANDOM, SET_RANDOM, SET_DEFAULT, SET_RANDOM};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	touch_zone_to_key_events i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	tzk_key_event_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side: stall in random bursts that start only while idling is on,
	// otherwise accept every beat. One assignment per falling edge.
	always @(negedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 19);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Present one event beat and hold it until the block takes it. Called and
	// returning at a falling edge; tvalid stays high for a back-to-back beat.
	task automatic send_event(input func_t kind, input logic [COORD_W-1:0] value);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	// Hold one register write until accepted; the caller drops cfg_valid.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Drop the input side and wait until every due beat has come, then let the
	// pipeline clear.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_setting(input setting_kind_t kind);
		case (kind)
			SET_HIGH: begin
				// every window as wide and as far right as it goes; overlap lets zone 0 win
				sh_row    = 12'hFFF;
				sh_tol    = 12'hFFF;
				sh_center = '{12'hFFF, 12'hFFF, 12'hFFF};
				sh_key    = '{12'hFFF, 12'h000, 12'h2FF};
			end
			SET_LOW: begin
				// zone 0 is disabled, so a touch at its center falls through to zone 1
				sh_row    = 12'h000;
				sh_tol    = 12'h000;
				sh_center = '{12'd0, 12'd0, 12'd2};
				sh_key    = '{12'd0, 12'd1, 12'd2};
			end
			SET_RANDOM: begin
				sh_row = $urandom_range(0, 4095);
				if ($urandom_range(0, 3) == 0)
					sh_tol = 12'($urandom);
				else
					sh_tol = {2'($urandom), 10'($urandom_range(0, 150))};
				for (int z = 0; z < NUM_ZONES; z++) begin
					sh_center[z] = $urandom_range(0, 4095);
					sh_key[z]    = ($urandom_range(0, 5) == 0) ? 12'd0 : 12'($urandom);
				end
			end
			default: begin
				sh_row    = RST_TARGET_ROW;
				sh_tol    = RST_ZONE_TOLERANCE;
				sh_center = '{RST_ZONE0_CENTER, RST_ZONE1_CENTER, RST_ZONE2_CENTER};
				sh_key    = '{RST_ZONE0_KEY, RST_ZONE1_KEY, RST_ZONE2_KEY};
			end
		endcase
		write_reg(REG_TARGET_ROW,     sh_row);
		write_reg(REG_ZONE_TOLERANCE, sh_tol);
		write_reg(REG_ZONE0_CENTER,   sh_center[0]);
		write_reg(REG_ZONE1_CENTER,   sh_center[1]);
		write_reg(REG_ZONE2_CENTER,   sh_center[2]);
		write_reg(REG_ZONE0_KEY,      sh_key[0]);
		write_reg(REG_ZONE1_KEY,      sh_key[1]);
		write_reg(REG_ZONE2_KEY,      sh_key[2]);
		cfg_valid <= 1'b0;
	endtask

	// One touch frame: optional touch, X and Y updates, then a frame end.
	// X mostly lands near a window edge or inside, Y mostly on the key row.
	task automatic send_touch_frame();
		int zone;
		int tol;
		int x;
		if ($urandom_range(0, 2) == 0) begin
			if ($urandom_range(0, 9) == 0)
				send_event(FUNC_TOUCH, '0);
			else if ($urandom_range(0, 1) == 0)
				send_event(FUNC_TOUCH, 16'd1);
			else
				send_event(FUNC_TOUCH, 16'($urandom));
		end
		if ($urandom_range(0, 3) != 0) begin
			zone = $urandom_range(0, NUM_ZONES - 1);
			tol  = int'(sh_tol[TOL_W-1:0]);
			if ($urandom_range(0, 9) == 0)
				x = $urandom_range(0, 65535);
			else
				x = int'(sh_center[zone]) + $urandom_range(0, 2 * tol + 6) - (tol + 3);
			send_event(FUNC_POS_X, 16'(x));
		end
		if ($urandom_range(0, 4) != 0) begin
			case ($urandom_range(0, 9))
				0:       send_event(FUNC_POS_Y, 16'($urandom));
				1:       send_event(FUNC_POS_Y, {4'd0, sh_row} + 16'd1);
				2:       send_event(FUNC_POS_Y, {4'd0, sh_row} - 16'd1);
				default: send_event(FUNC_POS_Y, {4'd0, sh_row});
			endcase
		end
		send_event(FUNC_FRAME_END, 16'($urandom));
	endtask

	initial begin
		int phase_start;
		int next_toggle;

		// hold reset, then release it on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening under the reset setting: rows at 2040, windows
		// 150..250, 450..550 and 750..850.
		send_event(FUNC_TOUCH,     16'd1);
		send_event(FUNC_POS_Y,     16'd2040);
		send_event(FUNC_POS_X,     16'd200);
		send_event(FUNC_FRAME_END, 16'h0000);   // press zone 0
		send_event(FUNC_FRAME_END, 16'hFFFF);   // no change, no beat
		send_event(FUNC_POS_X,     16'd150);    // low edge of zone 0
		send_event(FUNC_FRAME_END, 16'h0000);
		send_event(FUNC_POS_X,     16'd251);    // just past zone 0
		send_event(FUNC_FRAME_END, 16'h0000);   // release alone, last set
		send_event(FUNC_POS_X,     16'd450);
		send_event(FUNC_FRAME_END, 16'h0000);   // press zone 1
		send_event(FUNC_POS_X,     16'd850);
		send_event(FUNC_FRAME_END, 16'h0000);   // release then press
		send_event(FUNC_POS_X,     16'h8000);   // most negative X
		send_event(FUNC_FRAME_END, 16'h0000);
		send_event(FUNC_POS_X,     16'h7FFF);   // most positive X
		send_event(FUNC_TOUCH,     16'h8000);   // negative counts as down
		send_event(FUNC_FRAME_END, 16'h0000);
		send_event(FUNC_POS_X,     16'd749);
		send_event(FUNC_FRAME_END, 16'h0000);
		send_event(FUNC_POS_X,     16'd750);
		send_event(FUNC_FRAME_END, 16'h0000);   // press zone 2
		send_event(FUNC_POS_Y,     16'hFFFF);   // off the row
		send_event(FUNC_FRAME_END, 16'h0000);
		send_event(FUNC_TOUCH,     16'h0000);   // lift
		send_event(FUNC_FRAME_END, 16'h0000);

		// Random phases, each under a fresh setting; the last runs without idling.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			program_setting(phase_plan[p]);
			phase_start = beats_sent;
			next_toggle = beats_sent;
			while (beats_sent - phase_start < BEATS_PER_PHASE) begin
				if (beats_sent >= next_toggle) begin
					idle_on     = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
					next_toggle = beats_sent + 40;
				end
				if ($urandom_range(0, 4) == 0)
					send_event(func_t'($urandom_range(0, 3)), 16'($urandom));
				else
					send_touch_frame();
			end
		end

		// drain: nothing may stay due, then give a verdict
		idle_on = 1'b0;
		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hard limit well past the slowest correct run
	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/tzk_pkg.sv
rtl/core/tzk_cfg_regs.sv
rtl/core/tzk_zone_match.sv
rtl/core/tzk_out_fifo.sv
rtl/core/touch_zone_to_key_events.sv
tb/tzk_key_event_checker.sv
tb/tb_touch_zone_to_key_events.sv
